// ----- sv/cleb_pkg.sv -----
// cleb_pkg: shared constants, codes and types of the line edit buffer
// no dependencies; imported by cleb_cell and cursor_line_edit_buffer_unit
package cleb_pkg;

    localparam int LINE_MAX = 64;
    localparam int IDX_W    = $clog2(LINE_MAX);
    localparam int CNT_W    = $clog2(LINE_MAX + 1);
    localparam int CHAR_W   = 8;
    localparam int CFG_IDX_W = 2;

    // reset values of the control codes
    localparam logic [CHAR_W-1:0] HOME_RST   = 8'd45;
    localparam logic [CHAR_W-1:0] END_RST    = 8'd43;
    localparam logic [CHAR_W-1:0] RIGHT_RST  = 8'd42;
    localparam logic [CHAR_W-1:0] DELETE_RST = 8'd51;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOME   = 2'd0,
        REG_END    = 2'd1,
        REG_RIGHT  = 2'd2,
        REG_DELETE = 2'd3
    } cfg_reg_t;

    // operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_SHIFT  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [CNT_W-1:0]   cursor;
        logic [CHAR_W-1:0]  key;
    } cell_ctrl_t;

    typedef enum logic {
        FSM_IDLE  = 1'b0,
        FSM_FLUSH = 1'b1
    } fsm_state_t;

endpackage

// ----- sv/cursor_line_edit_buffer_unit.sv -----
// cursor_line_edit_buffer_unit: line editor with cursor over a chain of character cells
// depends on cleb_pkg and cleb_cell
// key transactions: one per cycle while idle, no result; edits finish in the cycle they are taken
// flush transaction: line_length output transactions (one for an empty line), one per cycle
// as the output is taken, shifted out of cell 0; input stalls until the flush is done
// reset: codes return to '-', '+', '*', '3'; length, cursor and output valid clear;
// cell contents are left as they are
module cursor_line_edit_buffer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cleb_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] key_char
    input  logic                          s_tuser,   // [0] command
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cleb_pkg::CHAR_W-1:0]   m_tdata,   // [7:0] out_char
    output logic                          m_tlast,
    output logic                          m_tuser,   // [0] empty_line
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cleb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cleb_pkg::CHAR_W-1:0]   cfg_data
);
    import cleb_pkg::*;

    logic [CHAR_W-1:0] home_code_reg, end_code_reg, right_code_reg, delete_code_reg;
    logic [CNT_W-1:0]  length_reg, length_next;
    logic [CNT_W-1:0]  cursor_reg, cursor_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    fsm_state_t        state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;
    logic              out_empty_reg, out_empty_next;
    logic              in_fire;
    logic              out_free;
    cell_ctrl_t        ctrl;
    logic [CHAR_W-1:0] cell_data [LINE_MAX];

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_char_reg;
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_empty_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_code_reg   <= HOME_RST;
            end_code_reg    <= END_RST;
            right_code_reg  <= RIGHT_RST;
            delete_code_reg <= DELETE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_HOME:   home_code_reg   <= cfg_data;
                REG_END:    end_code_reg    <= cfg_data;
                REG_RIGHT:  right_code_reg  <= cfg_data;
                REG_DELETE: delete_code_reg <= cfg_data;
                default:    home_code_reg   <= home_code_reg;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (s_tvalid && s_tuser)
                begin
                    state_next = FSM_FLUSH;
                end
            end
            FSM_FLUSH:
            begin
                if (out_free && rem_reg <= CNT_W'(1))
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // outputs: key decode, chain control, flush emission
    always_comb
    begin
        s_tready       = 1'b0;
        length_next    = length_reg;
        cursor_next    = cursor_reg;
        rem_next       = rem_reg;
        ctrl.op        = CELL_HOLD;
        ctrl.cursor    = cursor_reg;
        ctrl.key       = s_tdata;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                s_tready = 1'b1;
                if (in_fire && s_tuser)
                begin
                    rem_next    = length_reg;
                    length_next = '0;
                    cursor_next = '0;
                end
                else if (in_fire)
                begin
                    if (s_tdata == home_code_reg)
                    begin
                        cursor_next = '0;
                    end
                    else if (s_tdata == end_code_reg)
                    begin
                        cursor_next = length_reg;
                    end
                    else if (s_tdata == right_code_reg)
                    begin
                        if (cursor_reg < length_reg)
                        begin
                            cursor_next = cursor_reg + CNT_W'(1);
                        end
                    end
                    else if (s_tdata == delete_code_reg)
                    begin
                        if (cursor_reg < length_reg)
                        begin
                            ctrl.op     = CELL_DELETE;
                            length_next = length_reg - CNT_W'(1);
                        end
                    end
                    else if (length_reg < CNT_W'(LINE_MAX))
                    begin
                        ctrl.op     = CELL_INSERT;
                        length_next = length_reg + CNT_W'(1);
                        cursor_next = cursor_reg + CNT_W'(1);
                    end
                end
            end
            FSM_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (rem_reg == '0)
                    begin
                        out_char_next  = '0;
                        out_last_next  = 1'b1;
                        out_empty_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.op        = CELL_SHIFT;
                        out_char_next  = cell_data[0];
                        out_last_next  = (rem_reg == CNT_W'(1));
                        out_empty_next = 1'b0;
                        rem_next       = rem_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            length_reg    <= '0;
            cursor_reg    <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            length_reg    <= length_next;
            cursor_reg    <= cursor_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    // chain of character cells, cell 0 at line start
    for (genvar i = 0; i < LINE_MAX; i++)
    begin : g_cell
        logic [CHAR_W-1:0] left_d;
        logic [CHAR_W-1:0] right_d;
        if (i == 0)
        begin : g_first
            assign left_d = s_tdata;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == LINE_MAX - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end
        cleb_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .idx        (IDX_W'(i)),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i])
        );
    end

endmodule

// ----- sv/cleb_cell.sv -----
// cleb_cell: one character slot of the line chain
// depends on cleb_pkg for the control struct and widths
module cleb_cell (
    input  logic                     clk,
    input  cleb_pkg::cell_ctrl_t     ctrl,
    input  logic [cleb_pkg::IDX_W-1:0]  idx,
    input  logic [cleb_pkg::CHAR_W-1:0] left_data,
    input  logic [cleb_pkg::CHAR_W-1:0] right_data,
    output logic [cleb_pkg::CHAR_W-1:0] data
);
    import cleb_pkg::*;

    logic [CHAR_W-1:0] data_reg;
    logic [CHAR_W-1:0] data_next;
    logic [CNT_W-1:0]  pos;

    assign pos  = CNT_W'(idx);
    assign data = data_reg;

    // pick the new content from the key or a neighbor
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (pos == ctrl.cursor)
                begin
                    data_next = ctrl.key;
                end
                else if (pos > ctrl.cursor)
                begin
                    data_next = left_data;
                end
            end
            CELL_DELETE:
            begin
                if (pos >= ctrl.cursor)
                begin
                    data_next = right_data;
                end
            end
            CELL_SHIFT:
            begin
                data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // character storage
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
